// ===== rtl/core/lcfb_pkg.sv =====
// Package with the shared types, codes and constants of the link connection controller.
package lcfb_pkg;

   // Configuration port geometry.
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_BACKOFF = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_BACKOFF     = 1'd1;

   // Reset values of the configuration registers, in milliseconds.
   localparam logic [31:0] INITIAL_BACKOFF_RESET = 32'd1000;
   localparam logic [31:0] MAX_BACKOFF_RESET     = 32'd60000;

   // Saturation point of the failure counter.
   localparam logic [15:0] FAIL_TOP = 16'hFFFF;

   // Event kinds carried in the func field.
   localparam logic [2:0] FUNC_TICK         = 3'd0;
   localparam logic [2:0] FUNC_START        = 3'd1;
   localparam logic [2:0] FUNC_ASSOCIATED   = 3'd2;
   localparam logic [2:0] FUNC_DISCONNECTED = 3'd3;
   localparam logic [2:0] FUNC_GOT_ADDRESS  = 3'd4;
   localparam logic [2:0] FUNC_LOST_ADDRESS = 3'd5;

   // Connection state codes as reported on the result channel.
   localparam logic [2:0] CONN_DISCONNECTED = 3'd0;
   localparam logic [2:0] CONN_CONNECTING   = 3'd1;
   localparam logic [2:0] CONN_ASSOCIATED   = 3'd2;
   localparam logic [2:0] CONN_ONLINE       = 3'd3;
   localparam logic [2:0] CONN_BACKOFF      = 3'd4;

   // Internal connection state, one-hot.
   typedef enum logic [4:0] {
      LINK_DISCONNECTED = 5'b00001,
      LINK_CONNECTING   = 5'b00010,
      LINK_ASSOCIATED   = 5'b00100,
      LINK_ONLINE       = 5'b01000,
      LINK_BACKOFF      = 5'b10000
   } link_state_type;

   // One input item.
   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  drop_reason;
      logic [31:0] ip_address;
      logic        connect_ok;
   } req_payload_type;

   // One result item.
   typedef struct packed {
      logic [2:0]  conn_state;
      logic [31:0] current_address;
      logic [15:0] failure_count;
      logic [31:0] backoff_window;
      logic [7:0]  last_reason;
      logic        connect_request;
      logic        address_acquired;
      logic        address_lost;
      logic [7:0]  lost_reason;
   } rsp_payload_type;

   // Configuration register values handed to the state machine.
   typedef struct packed {
      logic [31:0] initial_backoff;
      logic [31:0] max_backoff;
   } csr_type;

   // Maps the one-hot state onto the reported code.
   function automatic logic [2:0] conn_code(input link_state_type state);
      logic [2:0] code;
      case (state)
         LINK_DISCONNECTED: code = CONN_DISCONNECTED;
         LINK_CONNECTING:   code = CONN_CONNECTING;
         LINK_ASSOCIATED:   code = CONN_ASSOCIATED;
         LINK_ONLINE:       code = CONN_ONLINE;
         LINK_BACKOFF:      code = CONN_BACKOFF;
         default:           code = CONN_DISCONNECTED;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/lcfb_chan_if.sv =====
// Valid/ready channel interface that carries one payload per transfer.
interface lcfb_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/lcfb_csr.sv =====
// Configuration registers for the initial and maximum retry windows.
module lcfb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lcfb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lcfb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output lcfb_pkg::csr_type                    csr_values
);
   import lcfb_pkg::*;

   logic [31:0] initial_backoff_ff;
   logic [31:0] initial_backoff_in;
   logic [31:0] max_backoff_ff;
   logic [31:0] max_backoff_in;

   // Decode the write port.
   always_comb begin
      initial_backoff_in = initial_backoff_ff;
      max_backoff_in     = max_backoff_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_BACKOFF: initial_backoff_in = csr_wdata;
            CSR_MAX_BACKOFF:     max_backoff_in     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Register storage, restored on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_backoff_ff <= INITIAL_BACKOFF_RESET;
         max_backoff_ff     <= MAX_BACKOFF_RESET;
      end else begin
         initial_backoff_ff <= initial_backoff_in;
         max_backoff_ff     <= max_backoff_in;
      end
   end

   assign csr_values.initial_backoff = initial_backoff_ff;
   assign csr_values.max_backoff     = max_backoff_ff;
endmodule

// ===== rtl/core/lcfb_fsm.sv =====
// Connection state machine with failure count, retry window and countdown.
module lcfb_fsm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  lcfb_pkg::req_payload_type item,
   input  lcfb_pkg::csr_type         csr_values,
   output lcfb_pkg::rsp_payload_type result
);
   import lcfb_pkg::*;

   link_state_type state_ff;
   link_state_type state_in;
   logic [15:0]    failures_ff;
   logic [15:0]    failures_in;
   logic [31:0]    window_ff;
   logic [31:0]    window_in;
   logic [31:0]    remaining_ff;
   logic [31:0]    remaining_in;
   logic [31:0]    address_ff;
   logic [31:0]    address_in;
   logic [7:0]     reason_ff;
   logic [7:0]     reason_in;

   logic [31:0] remaining_dec;
   logic [15:0] failures_inc;
   logic [32:0] window_double;
   logic [31:0] window_capped;
   logic        request;
   logic        acquired;
   logic        lost;
   logic [7:0]  lost_reason;

   // Shared arithmetic: countdown step, saturating count, doubled window capped at the maximum.
   always_comb begin
      remaining_dec = (remaining_ff != 32'd0) ? (remaining_ff - 32'd1) : 32'd0;
      failures_inc  = (failures_ff < FAIL_TOP) ? (failures_ff + 16'd1) : failures_ff;
      window_double = {window_ff, 1'b0};
      window_capped = (window_double > {1'b0, csr_values.max_backoff})
                      ? csr_values.max_backoff : window_double[31:0];
   end

   // Next state and pulses for the current event.
   always_comb begin
      state_in     = state_ff;
      failures_in  = failures_ff;
      window_in    = window_ff;
      remaining_in = remaining_ff;
      address_in   = address_ff;
      reason_in    = reason_ff;
      request      = 1'b0;
      acquired     = 1'b0;
      lost         = 1'b0;
      lost_reason  = 8'd0;
      case (item.func)
         FUNC_TICK: begin
            if (state_ff == LINK_BACKOFF) begin
               remaining_in = remaining_dec;
               if (remaining_dec == 32'd0) begin
                  request = 1'b1;
                  if (item.connect_ok) begin
                     state_in = LINK_CONNECTING;
                  end else begin
                     remaining_in = window_ff;
                  end
               end
            end
         end
         FUNC_START: begin
            request = 1'b1;
            if (item.connect_ok) begin
               state_in = LINK_CONNECTING;
            end else begin
               failures_in  = 16'd1;
               window_in    = csr_values.initial_backoff;
               remaining_in = csr_values.initial_backoff;
               state_in     = LINK_BACKOFF;
            end
         end
         FUNC_ASSOCIATED: begin
            state_in    = LINK_ASSOCIATED;
            failures_in = 16'd0;
            window_in   = csr_values.initial_backoff;
         end
         FUNC_DISCONNECTED: begin
            reason_in   = item.drop_reason;
            failures_in = failures_inc;
            // The first failure restarts the window; later ones double it.
            if (failures_inc == 16'd1) begin
               window_in = csr_values.initial_backoff;
            end else begin
               window_in = window_capped;
            end
            remaining_in = window_in;
            address_in   = 32'd0;
            state_in     = LINK_BACKOFF;
            if (state_ff == LINK_ONLINE) begin
               lost        = 1'b1;
               lost_reason = item.drop_reason;
            end
         end
         FUNC_GOT_ADDRESS: begin
            address_in  = item.ip_address;
            state_in    = LINK_ONLINE;
            failures_in = 16'd0;
            window_in   = csr_values.initial_backoff;
            acquired    = 1'b1;
         end
         FUNC_LOST_ADDRESS: begin
            address_in = 32'd0;
            state_in   = LINK_ASSOCIATED;
            lost       = (state_ff == LINK_ONLINE);
         end
         default: begin
         end
      endcase
   end

   // State registers advance once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LINK_DISCONNECTED;
         failures_ff  <= 16'd0;
         window_ff    <= INITIAL_BACKOFF_RESET;
         remaining_ff <= 32'd0;
         address_ff   <= 32'd0;
         reason_ff    <= 8'd0;
      end else if (advance) begin
         state_ff     <= state_in;
         failures_ff  <= failures_in;
         window_ff    <= window_in;
         remaining_ff <= remaining_in;
         address_ff   <= address_in;
         reason_ff    <= reason_in;
      end
   end

   // Status snapshot after the event.
   always_comb begin
      result.conn_state       = conn_code(state_in);
      result.current_address  = address_in;
      result.failure_count    = failures_in;
      result.backoff_window   = window_in;
      result.last_reason      = reason_in;
      result.connect_request  = request;
      result.address_acquired = acquired;
      result.address_lost     = lost;
      result.lost_reason      = lost_reason;
   end
endmodule

// ===== rtl/core/link_connect_fsm_exponential_backoff.sv =====
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while rsp_chan is ready; both registers hand off while full.
// The state machine updates when an item moves from the input register to the result register.
// Reset is synchronous: both stages empty, state disconnected, count zero, window 1000 ms,
// initial and maximum windows back to 1000 ms and 60000 ms.
module link_connect_fsm_exponential_backoff (
   input  logic                                 clock,
   input  logic                                 reset,
   lcfb_chan_if.sink                            req_chan,
   lcfb_chan_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [lcfb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lcfb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import lcfb_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_item_ff;
   rsp_payload_type fsm_result;
   csr_type         csr_values;
   logic            req_transfer;
   logic            advance;

   // Configuration registers.
   lcfb_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .csr_values (csr_values)
   );

   // An item moves on when the result register is empty or being drained.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_transfer = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_transfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_item_ff <= req_chan.payload;
      end
   end

   // State machine between the two registers.
   lcfb_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (in_item_ff),
      .csr_values (csr_values),
      .result     (fsm_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= fsm_result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

`ifndef SYNTHESIS
   // A start event always issues a connect request in its result.
   a_start_requests: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.func == FUNC_START)
      |=> (out_valid_ff && out_item_ff.connect_request))
      else $error("start event did not issue a connect request");

   // An acquired address leaves the link online.
   a_acquired_online: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.address_acquired)
      |-> (out_item_ff.conn_state == CONN_ONLINE))
      else $error("address acquired without online state");

   // A result waiting for the sink is not overwritten.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> !$past(advance))
      else $error("result register advanced while stalled");
`endif
endmodule
